// ----- rtl/sbi_pkg.sv -----
// Package for the segment/box intersection block: widths, word types,
// face and register codes, and the restoring divide step.
// No dependencies.
`default_nettype none

package sbi_pkg;

  // Coordinate format: signed Q(CW-FB).FB
  localparam int CW = 32;
  localparam int FB = 16;
  // Differences of two coordinates
  localparam int DW = CW + 1;
  // Segment parameter u in [0, 2^FB]
  localparam int UW = FB + 1;
  // Product of a difference and u
  localparam int PW = DW + UW + 1;
  // Crossing coordinate
  localparam int XW = DW + 1;

  // Quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = FB / DIV_STEPS;

  // Stages held inside one face lane: check, divide, multiply, compare
  localparam int LANE_ST = DIV_STAGES + 3;
  // Whole pipeline: input stage, lane stages, output stage
  localparam int NST = LANE_ST + 2;

  localparam int NFACE = 6;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic        [DW-1:0] mag_t;
  typedef logic        [FB-1:0] quo_t;
  typedef logic        [UW-1:0] u_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] xcoord_t;

  typedef enum logic [2:0] {
    FACE_NZ = 3'd0,
    FACE_PZ = 3'd1,
    FACE_NY = 3'd2,
    FACE_PY = 3'd3,
    FACE_NX = 3'd4,
    FACE_PX = 3'd5
  } face_t;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5,
    REG_POLY  = 3'd6
  } cfg_reg_t;

  // One restoring step: the remainder stays below the divisor when it enters below it
  typedef struct packed {
    mag_t rem;
    logic bit_q;
  } div_step_t;

  function automatic div_step_t div_step(input mag_t rem, input mag_t ad);
    logic [DW:0] sh;
    div_step_t   res;
    sh = {rem, 1'b0};
    if (sh >= {1'b0, ad}) begin
      res.rem   = DW'(sh - {1'b0, ad});
      res.bit_q = 1'b1;
    end else begin
      res.rem   = DW'(sh);
      res.bit_q = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sbi_if.sv -----
// Valid/ready channel interfaces for segment words and result words.
// Depends on sbi_pkg.
`default_nettype none

interface sbi_in_if;
  import sbi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface sbi_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] face_index;

  modport source (output valid, hit, face_index, input ready);
  modport sink   (input valid, hit, face_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/sbi_face_lane.sv -----
// One box face: range check, pipelined restoring divide for u,
// interpolation of the two other axes and the inclusive box test.
// Depends on sbi_pkg.
`default_nettype none

module sbi_face_lane (
  input  wire                          clk,
  input  wire  [sbi_pkg::LANE_ST-1:0]  ld,
  input  wire  sbi_pkg::diff_t         num,
  input  wire  sbi_pkg::diff_t         den,
  input  wire  sbi_pkg::coord_t        sb1,
  input  wire  sbi_pkg::diff_t         db1,
  input  wire  sbi_pkg::coord_t        sb2,
  input  wire  sbi_pkg::diff_t         db2,
  input  wire  sbi_pkg::coord_t        lo1,
  input  wire  sbi_pkg::coord_t        hi1,
  input  wire  sbi_pkg::coord_t        lo2,
  input  wire  sbi_pkg::coord_t        hi2,
  output logic                         hit
);
  import sbi_pkg::*;

  typedef struct packed {
    logic   ok;
    logic   eq;
    mag_t   rem;
    mag_t   ad;
    quo_t   quo;
    coord_t sb1;
    diff_t  db1;
    coord_t sb2;
    diff_t  db2;
  } dstage_t;

  typedef struct packed {
    logic   ok;
    coord_t sb1;
    coord_t sb2;
    prod_t  p1;
    prod_t  p2;
  } mstage_t;

  dstage_t dv_r   [0:DIV_STAGES];
  dstage_t dv_nxt [0:DIV_STAGES];
  mstage_t mu_r, mu_nxt;
  logic    hit_r, hit_nxt;

  // Check stage: u in [0,1] decided exactly from the signs and magnitudes,
  // then divide stages: DIV_STEPS quotient bits each
  always_comb begin
    mag_t      an;
    mag_t      ad;
    div_step_t st;
    an = num[DW-1] ? mag_t'(-num) : mag_t'(num);
    ad = den[DW-1] ? mag_t'(-den) : mag_t'(den);
    dv_nxt[0].ok  = (den != '0) && !((num != '0) && (num[DW-1] != den[DW-1]))
                    && (an <= ad);
    dv_nxt[0].eq  = (an == ad);
    dv_nxt[0].rem = an;
    dv_nxt[0].ad  = ad;
    dv_nxt[0].quo = '0;
    dv_nxt[0].sb1 = sb1;
    dv_nxt[0].db1 = db1;
    dv_nxt[0].sb2 = sb2;
    dv_nxt[0].db2 = db2;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      dv_nxt[j] = dv_r[j-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        st = div_step(dv_nxt[j].rem, dv_nxt[j].ad);
        dv_nxt[j].rem = st.rem;
        dv_nxt[j].quo = {dv_nxt[j].quo[FB-2:0], st.bit_q};
      end
    end
  end

  // Multiply stage: d * u for both other axes
  always_comb begin
    u_t u;
    u = dv_r[DIV_STAGES].eq ? u_t'(1) << FB : {1'b0, dv_r[DIV_STAGES].quo};
    mu_nxt.ok  = dv_r[DIV_STAGES].ok;
    mu_nxt.sb1 = dv_r[DIV_STAGES].sb1;
    mu_nxt.sb2 = dv_r[DIV_STAGES].sb2;
    mu_nxt.p1  = PW'(dv_r[DIV_STAGES].db1) * PW'($signed({1'b0, u}));
    mu_nxt.p2  = PW'(dv_r[DIV_STAGES].db2) * PW'($signed({1'b0, u}));
  end

  // Compare stage: crossing point inside the box, bounds included
  always_comb begin
    xcoord_t x1;
    xcoord_t x2;
    x1 = XW'(mu_r.sb1) + XW'(mu_r.p1 >>> FB);
    x2 = XW'(mu_r.sb2) + XW'(mu_r.p2 >>> FB);
    hit_nxt = mu_r.ok && (x1 >= XW'(lo1)) && (x1 <= XW'(hi1))
                      && (x2 >= XW'(lo2)) && (x2 <= XW'(hi2));
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= DIV_STAGES; j++) begin
      if (ld[j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
    if (ld[DIV_STAGES+1]) begin
      mu_r <= mu_nxt;
    end
    if (ld[DIV_STAGES+2]) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

// ----- rtl/segment_box_intersect.sv -----
// Top level: segment against axis-aligned box, six face lanes in parallel.
// Depends on sbi_pkg, sbi_if (sbi_in_if, sbi_out_if) and sbi_face_lane.
//
//  channel  | dir | word                                   | handshake
//  ---------+-----+----------------------------------------+-------------
//  in_word  | in  | start_x/y/z, end_x/y/z (Q16.16 signed) | valid/ready
//  out_word | out | hit, face_index                        | valid/ready
//  cfg_*    | in  | box bounds, is_polygon                 | write enable
//
// One word enters per cycle unless the output stalls; NST = DIV_STAGES + 5 = 13
// register stages, their depth set by the restoring divide for u at two quotient
// bits per stage.
// Each stage holds its word until the next stage is free, so bubbles
// collapse and a stalled output only holds back stages that are full.
// Reset (rst_n, synchronous) clears valid bits and the box registers.
`default_nettype none

module segment_box_intersect (
  input  wire                 clk,
  input  wire                 rst_n,
  sbi_in_if.sink              in_word,
  sbi_out_if.source           out_word,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [sbi_pkg::CW-1:0] cfg_data
);
  import sbi_pkg::*;

  coord_t box_lo_r [0:2];
  coord_t box_hi_r [0:2];
  logic   poly_r;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST:0]   adv;

  coord_t s_r   [0:2];
  diff_t  d_r   [0:2];
  diff_t  num_r [0:NFACE-1];

  logic [NFACE-1:0] lane_hit;
  logic  hit_r, hit_nxt;
  face_t face_r, face_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_r[k] <= '0;
        box_hi_r[k] <= '0;
      end
      poly_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: box_lo_r[0] <= cfg_data;
        REG_MIN_Y: box_lo_r[1] <= cfg_data;
        REG_MIN_Z: box_lo_r[2] <= cfg_data;
        REG_MAX_X: box_hi_r[0] <= cfg_data;
        REG_MAX_Y: box_hi_r[1] <= cfg_data;
        REG_MAX_Z: box_hi_r[2] <= cfg_data;
        REG_POLY:  poly_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when empty or when its word moves on
  always_comb begin
    adv[NST] = out_word.ready;
    for (int k = NST-1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_word.valid;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_word.ready = adv[0];

  // Input stage: deltas and per-face numerators
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s_r[0] <= in_word.start_x;
      s_r[1] <= in_word.start_y;
      s_r[2] <= in_word.start_z;
      d_r[0] <= DW'(in_word.end_x) - DW'(in_word.start_x);
      d_r[1] <= DW'(in_word.end_y) - DW'(in_word.start_y);
      d_r[2] <= DW'(in_word.end_z) - DW'(in_word.start_z);
      num_r[0] <= DW'(box_lo_r[2]) - DW'(in_word.start_z);
      num_r[1] <= DW'(box_hi_r[2]) - DW'(in_word.start_z);
      num_r[2] <= DW'(box_lo_r[1]) - DW'(in_word.start_y);
      num_r[3] <= DW'(box_hi_r[1]) - DW'(in_word.start_y);
      num_r[4] <= DW'(box_lo_r[0]) - DW'(in_word.start_x);
      num_r[5] <= DW'(box_hi_r[0]) - DW'(in_word.start_x);
    end
  end

  // Face lanes: face f lies on axis 2 - f/2
  for (genvar f = 0; f < NFACE; f++) begin : g_face
    localparam int AX = 2 - f / 2;
    localparam int B1 = (AX == 0) ? 1 : 0;
    localparam int B2 = (AX == 2) ? 1 : 2;

    sbi_face_lane u_lane (
      .clk (clk),
      .ld  (adv[LANE_ST:1]),
      .num (num_r[f]),
      .den (d_r[AX]),
      .sb1 (s_r[B1]),
      .db1 (d_r[B1]),
      .sb2 (s_r[B2]),
      .db2 (d_r[B2]),
      .lo1 (box_lo_r[B1]),
      .hi1 (box_hi_r[B1]),
      .lo2 (box_lo_r[B2]),
      .hi2 (box_hi_r[B2]),
      .hit (lane_hit[f])
    );
  end

  // Output stage: first face in fixed order wins
  always_comb begin
    hit_nxt  = poly_r && (lane_hit != '0);
    face_nxt = FACE_NZ;
    if (poly_r) begin
      for (int f = NFACE-1; f >= 0; f--) begin
        if (lane_hit[f]) begin
          face_nxt = face_t'(3'(f));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      hit_r  <= hit_nxt;
      face_r <= face_nxt;
    end
  end

  assign out_word.valid      = v_r[NST-1];
  assign out_word.hit        = hit_r;
  assign out_word.face_index = face_r;

`ifndef ASSERT_OFF
  a_miss_face_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.hit |-> out_word.face_index == FACE_NZ)
    else $error("miss word carries a nonzero face");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> out_word.face_index <= FACE_PX)
    else $error("face index out of range");

  a_poly_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !poly_r |-> !out_word.hit)
    else $error("hit reported for a non-polygon object");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> v_r[0])
    else $error("accepted word not held in the input stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.ready |=> out_word.valid && $stable(hit_r)
      && $stable(face_r))
    else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for segment_box_intersect: directed segments, then random segments
// against several box settings, checked word by word against a local predictor.
// Depends on sbi_pkg, sbi_if and the segment_box_intersect RTL.
`timescale 1ns / 1ps

module tb;
  import sbi_pkg::*;

  typedef struct {
    coord_t seg [6];   // start x,y,z then end x,y,z
    bit     typed;     // expected result given in the row
    bit     hit;
    face_t  face;
  } seg_row_t;

  typedef struct {
    bit    hit;
    face_t face;
  } hit_word_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t TWO  = 32'sh0002_0000;
  localparam coord_t FIVE = 32'sh0005_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam int WD_LIMIT = 20000;
  localparam int N_PHASE  = 8;
  localparam int PHASE_N  = 125;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_MIN_X;
  logic [CW-1:0] cfg_data = '0;

  sbi_in_if  in_word ();
  sbi_out_if out_word ();

  segment_box_intersect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the box registers, index 0 x, 1 y, 2 z
  coord_t box_lo [3];
  coord_t box_hi [3];
  bit     poly_q;

  hit_word_t hit_q [$];
  int  fails = 0;
  bit  idle_on = 1'b1;
  int  out_stall = 0;
  int  quiet_cycles = 0;

  // first face, tried in the order -z,+z,-y,+y,-x,+x, that the segment crosses
  function automatic hit_word_t first_face(input coord_t sg [6]);
    longint s [3], d [3], lo [3], hi [3];
    longint c, num, den, an, ad, rem, u, hk, lk, xc;
    int axis;
    bit ok;
    hit_word_t r;
    r.hit = 1'b0;
    r.face = FACE_NZ;
    if (!poly_q) return r;
    for (int k = 0; k < 3; k++) begin
      s[k] = longint'(sg[k]);
      d[k] = longint'(sg[k+3]) - s[k];
      lo[k] = longint'(box_lo[k]);
      hi[k] = longint'(box_hi[k]);
    end
    for (int f = 0; f < NFACE; f++) begin
      axis = 2 - f / 2;
      c = f[0] ? hi[axis] : lo[axis];
      num = c - s[axis];
      den = d[axis];
      if (den == 0) continue;
      if (num != 0 && ((num < 0) != (den < 0))) continue;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      if (an > ad) continue;
      if (an == ad) begin
        u = longint'(1) << FB;
      end else begin
        rem = an;
        u = 0;
        for (int i = 0; i < FB; i++) begin
          rem = rem << 1;
          u = u << 1;
          if (rem >= ad) begin
            rem = rem - ad;
            u = u | 1;
          end
        end
      end
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (k == axis) continue;
        // floor(d*u / 2^FB), split so the low part stays nonnegative
        if (d[k] >= 0) hk = d[k] >>> FB;
        else hk = -((-d[k] + (longint'(1) << FB) - 1) >>> FB);
        lk = d[k] - hk * (longint'(1) << FB);
        xc = s[k] + hk * u + ((lk * u) >>> FB);
        if (xc < lo[k] || xc > hi[k]) ok = 1'b0;
      end
      if (ok) begin
        r.hit = 1'b1;
        r.face = face_t'(f);
        return r;
      end
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones, none while idling is off
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // coordinate on or near the box span of one axis, or now and then anywhere
  function automatic coord_t near_coord(input coord_t lo, input coord_t hi);
    longint span;
    case ($urandom_range(0, 9))
      0, 1: return coord_t'($urandom);
      2: return lo;
      3: return hi;
      4: return coord_t'(longint'(lo) + $signed($urandom_range(0, 8)) - 4);
      5: return coord_t'(longint'(hi) + $signed($urandom_range(0, 8)) - 4);
      default: begin
        span = longint'(hi) - longint'(lo);
        if (span < 0) span = -span;
        span = span + 1;
        return coord_t'(longint'(lo) + longint'($urandom) % span);
      end
    endcase
  endfunction

  // wait until every result is in, then let the pipe empty
  task automatic drain();
    in_word.valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (NST + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_box(input coord_t mnx, input coord_t mny, input coord_t mnz,
                         input coord_t mxx, input coord_t mxy, input coord_t mxz,
                         input bit poly);
    drain();
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MIN_Z, mnz);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
    write_reg(REG_MAX_Z, mxz);
    // upper bits of the flag word are don't-care
    write_reg(REG_POLY, {$urandom} & ~32'd1 | {31'd0, poly});
    cfg_we <= 1'b0;
    box_lo = '{mnx, mny, mnz};
    box_hi = '{mxx, mxy, mxz};
    poly_q = poly;
  endtask

  task automatic send_seg(input seg_row_t row);
    int gap;
    hit_word_t w;
    gap = gap_len();
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.start_x <= row.seg[0];
    in_word.start_y <= row.seg[1];
    in_word.start_z <= row.seg[2];
    in_word.end_x <= row.seg[3];
    in_word.end_y <= row.seg[4];
    in_word.end_z <= row.seg[5];
    do @(posedge clk); while (!in_word.ready);
    if (row.typed) begin
      w.hit = row.hit;
      w.face = row.face;
    end else begin
      w = first_face(row.seg);
    end
    hit_q.push_back(w);
  endtask

  function automatic seg_row_t mk(input coord_t sx, input coord_t sy, input coord_t sz,
                                  input coord_t ex, input coord_t ey, input coord_t ez,
                                  input bit typed, input bit hit, input face_t face);
    seg_row_t r;
    r.seg = '{sx, sy, sz, ex, ey, ez};
    r.typed = typed;
    r.hit = hit;
    r.face = face;
    return r;
  endfunction

  // result side stalls and checking, plus the watchdog
  always @(posedge clk) begin
    hit_word_t w;
    if (out_stall > 0) begin
      out_word.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_word.ready <= 1'b0;
      out_stall <= gap_len();
    end else begin
      out_word.ready <= 1'b1;
    end

    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, WD_LIMIT);
      $display("segment_box_intersect regression: fail");
      $finish;
    end

    if (rst_n && out_word.valid && out_word.ready) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b face=%0d", $time,
                 out_word.hit, out_word.face_index);
        fails++;
      end else begin
        w = hit_q.pop_front();
        if (out_word.hit !== w.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, w.hit, out_word.hit);
          fails++;
        end
        if (out_word.face_index !== w.face) begin
          $display("%0t: face_index expected %0d actual %0d", $time,
                   w.face, out_word.face_index);
          fails++;
        end
      end
    end
  end

  initial begin
    seg_row_t rows_reset [$];
    seg_row_t rows_unit [$];
    seg_row_t row;
    coord_t lo3 [3];
    coord_t hi3 [3];
    bit pol;

    in_word.valid <= 1'b0;
    in_word.start_x <= '0;
    in_word.start_y <= '0;
    in_word.start_z <= '0;
    in_word.end_x <= '0;
    in_word.end_y <= '0;
    in_word.end_z <= '0;
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    poly_q = 1'b0;

    // after reset the object is not a polygon: every segment misses
    rows_reset.push_back(mk(0, 0, -TWO, 0, 0, TWO, 1, 0, FACE_NZ));
    rows_reset.push_back(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0, FACE_NZ));
    rows_reset.push_back(mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, 0, FACE_NZ));
    rows_reset.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, FACE_NZ));

    // unit box +-1
    rows_unit.push_back(mk(0, 0, -TWO, 0, 0, TWO, 1, 1, FACE_NZ));
    rows_unit.push_back(mk(0, -TWO, 0, 0, TWO, 0, 1, 1, FACE_NY));
    rows_unit.push_back(mk(TWO, 0, 0, -TWO, 0, 0, 1, 1, FACE_NX));
    rows_unit.push_back(mk(FIVE, FIVE, -TWO, FIVE, FIVE, TWO, 1, 0, FACE_NZ));
    rows_unit.push_back(mk(0, 0, TWO, 0, 0, -TWO, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(ONE, ONE, -TWO, ONE, ONE, TWO, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(0, 0, 0, FIVE, 0, 0, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(0, 0, ONE, 0, 0, ONE, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(-FIVE, 0, 0, -TWO, 0, 0, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(-TWO, 0, ONE + 1, TWO, 0, -ONE - 1, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, FACE_NZ));
    rows_unit.push_back(mk(-TWO, TWO, 0, TWO, -TWO, 0, 0, 0, FACE_NZ));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows_reset[i]) send_seg(rows_reset[i]);
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b1);
    foreach (rows_unit[i]) send_seg(rows_unit[i]);

    // random phases: extreme box, inverted, zero, non-polygon, random boxes
    for (int p = 0; p < N_PHASE; p++) begin
      pol = 1'b1;
      for (int k = 0; k < 3; k++) begin
        lo3[k] = coord_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        hi3[k] = lo3[k] + coord_t'($urandom_range(0, 32'h0010_0000));
      end
      case (p)
        0: begin lo3 = '{CMIN, CMIN, CMIN}; hi3 = '{CMAX, CMAX, CMAX}; end
        1: begin lo3[1] = ONE; hi3[1] = -ONE; end
        2: begin lo3 = '{0, 0, 0}; hi3 = '{0, 0, 0}; end
        3: pol = 1'b0;
        4: begin lo3[0] = CMIN; hi3[2] = CMAX; end
        default: ;
      endcase
      idle_on = (p != 5);
      set_box(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2], pol);
      for (int n = 0; n < PHASE_N; n++) begin
        row.typed = 1'b0;
        row.hit = 1'b0;
        row.face = FACE_NZ;
        if ($urandom_range(0, 4) == 0) begin
          foreach (row.seg[k]) row.seg[k] = coord_t'($urandom);
        end else begin
          for (int k = 0; k < 3; k++) begin
            row.seg[k] = near_coord(box_lo[k], box_hi[k]);
            row.seg[k+3] = near_coord(box_lo[k], box_hi[k]);
          end
          // sometimes set one start coordinate to one below the x lower bound
          if ($urandom_range(0, 1)) begin
            row.seg[$urandom_range(0, 2)] = coord_t'(longint'(box_lo[0]) - ONE);
          end
        end
        if ($urandom_range(0, 199) == 0) drain();
        send_seg(row);
      end
    end

    drain();
    repeat (NST + 5) @(posedge clk);
    if (fails == 0) begin
      $display("segment_box_intersect regression: pass");
    end else begin
      $display("segment_box_intersect regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sbi_pkg.sv
rtl/sbi_if.sv
rtl/sbi_face_lane.sv
rtl/segment_box_intersect.sv
tb/tb.sv
